FILE: src/pcv_pkg.sv
package pcv_pkg;

  localparam int WORD_W  = 16;
  localparam int INDEX_W = 3;
  localparam int NIB_W   = 4;

  localparam logic [INDEX_W-1:0] INDEX_FIRST = 3'd0;
  localparam logic [INDEX_W-1:0] INDEX_LAST  = 3'd7;

  localparam logic [WORD_W-1:0] CRC_POLY  = 16'h3000;
  localparam logic [WORD_W-1:0] WORD_ZERO = 16'h0000;
  localparam logic [WORD_W-1:0] WORD_ONES = 16'hFFFF;

  typedef enum logic [1:0] {
    VERDICT_MATCH    = 2'd0,
    VERDICT_MISMATCH = 2'd1,
    VERDICT_FLOATING = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [NIB_W-1:0] stored_crc;
    logic [NIB_W-1:0] computed_crc;
    verdict_t         verdict;
  } result_t;

  // The byte enters the low end of the remainder, then eight shift steps
  // with feedback from the top bit.
  function automatic logic [WORD_W-1:0] fold_byte(input logic [WORD_W-1:0] rem_in,
                                                  input logic [7:0] byte_in);
    logic [WORD_W-1:0] rem;
    rem = rem_in ^ {8'h00, byte_in};
    for (int i = 0; i < 8; i++) begin
      if (rem[WORD_W-1]) begin
        rem = {rem[WORD_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        rem = {rem[WORD_W-2:0], 1'b0};
      end
    end
    return rem;
  endfunction

endpackage

FILE: src/prom_crc4_validator.sv
// Channel   Direction  tdata                                    tuser
// s_axis    in         prom_word[15:0]                          word_pos[2:0]
// m_axis    out        verdict[1:0], computed_crc[5:2],         -
//                      stored_crc[9:6], zeros[15:10]
//
// One word is accepted in every cycle unless an index-7 word waits for the
// output register. A word is registered on input, then folded into the running
// remainder; the verdict for an index-7 word is then loaded into the output register.
// The verdict is held in an output register; while it waits for m_axis_tready,
// further words keep flowing until another index-7 word needs the register.
// Synchronous reset clears both valid flags and the remainder and sets the all-zero and all-ones flags.
module prom_crc4_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // prom_word[15:0]
  input  logic [2:0]  s_axis_tuser,  // word_pos[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // verdict[1:0], computed_crc[5:2], stored_crc[9:6]
);
  import pcv_pkg::*;

  // Input register.
  logic               in_valid;
  logic [WORD_W-1:0]  in_word;
  logic [INDEX_W-1:0] in_index;

  // Running state.
  logic [WORD_W-1:0] remainder;
  logic              all_zero;
  logic              all_ones;
  logic [WORD_W-1:0] remainder_next;
  logic              all_zero_next;
  logic              all_ones_next;

  // Output register.
  logic    out_valid;
  result_t out_result;
  result_t result_next;

  logic              is_first;
  logic              is_last;
  logic              advance;
  logic [WORD_W-1:0] rem_base;
  logic [WORD_W-1:0] folded;
  logic [WORD_W-1:0] rem_mid;

  assign is_first = (in_index == INDEX_FIRST);
  assign is_last  = (in_index == INDEX_LAST);

  // A word that produces no verdict never waits on the output side.
  assign advance       = in_valid && (!is_last || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_comb begin
    rem_base       = is_first ? WORD_ZERO : remainder;
    all_zero_next  = (is_first || all_zero) && (in_word == WORD_ZERO);
    all_ones_next  = (is_first || all_ones) && (in_word == WORD_ONES);
    folded         = is_last ? {in_word[15:8], 8'h00} : in_word;
    rem_mid        = fold_byte(rem_base, folded[15:8]);
    remainder_next = fold_byte(rem_mid, folded[7:0]);

    result_next.computed_crc = remainder_next[WORD_W-1 -: NIB_W];
    result_next.stored_crc   = in_word[NIB_W-1:0];
    if (all_zero_next || all_ones_next) begin
      result_next.verdict = VERDICT_FLOATING;
    end else if (result_next.computed_crc == result_next.stored_crc) begin
      result_next.verdict = VERDICT_MATCH;
    end else begin
      result_next.verdict = VERDICT_MISMATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      remainder <= WORD_ZERO;
      all_zero  <= 1'b1;
      all_ones  <= 1'b1;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        remainder <= remainder_next;
        all_zero  <= all_zero_next;
        all_ones  <= all_ones_next;
      end
      if (advance && is_last) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_word  <= s_axis_tdata;
      in_index <= s_axis_tuser;
    end
    if (advance && is_last) begin
      out_result <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b000000, out_result};

endmodule
